### src/assert_macros.svh
// Assertion helpers shared by the RTL modules.
// Every macro expects signals named clk and arst_n in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Antecedent in this cycle implies the consequent in the next cycle.
`define ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

// Antecedent implies the consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

`endif

### src/mlp_pkg.sv
package mlp_pkg;

	localparam int NUM_KEYS = 10;

	// Characters of interest
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// Prefix tracking: 0..6 inside the prefix, 7 wants a space, 8 in the body
	localparam logic [55:0] PREFIX_STR = "METRICS";
	localparam logic [3:0]  PREFIX_LEN = 4'd7;
	localparam logic [3:0]  POS_BODY   = 4'd8;

	// Key table, in output field order; strings right-aligned in 16 bytes
	localparam logic [127:0] KEY_STR [NUM_KEYS] = '{
		{"uptime", "_sec"}, "active", "accepted", "disconnected", "devices",
		"received", {"ack", "_sent"}, {"parse", "_errors"}, {"broadcast", "_errors"},
		{"msg_per", "_sec"}
	};
	localparam logic [4:0] KEY_LEN [NUM_KEYS] = '{
		5'd10, 5'd6, 5'd8, 5'd12, 5'd7, 5'd8, 5'd8, 5'd12, 5'd16, 5'd11
	};

	typedef enum logic [1:0] {
		PH_GAP = 2'd0,
		PH_KEY = 2'd1,
		PH_EQ  = 2'd2,
		PH_VAL = 2'd3
	} phase_t;

	typedef struct packed {
		logic [3:0]                 prefix_pos;
		phase_t                     phase;
		logic [4:0]                 key_len;
		logic [NUM_KEYS-1:0]        cand;
		logic [63:0]                acc;
		logic                       val_bad;
		logic                       failed;
		logic [NUM_KEYS-1:0][63:0]  vals;
	} parse_state_t;

	// Line end handed to the tail pipeline: state plus up to three bytes
	typedef struct packed {
		parse_state_t     st;
		logic [2:0][7:0]  bytes;
		logic [1:0]       count;
	} tail_item_t;

	function automatic parse_state_t init_state();
		parse_state_t r;
		r.prefix_pos = '0;
		r.phase      = PH_GAP;
		r.key_len    = '0;
		r.cand       = '1;
		r.acc        = '0;
		r.val_bad    = 1'b0;
		r.failed     = 1'b0;
		r.vals       = '0;
		return r;
	endfunction

	function automatic logic [7:0] prefix_byte(logic [2:0] pos);
		logic [2:0] sel;
		sel = 3'd6 - pos;
		return PREFIX_STR[{sel, 3'b000} +: 8];
	endfunction

	// Character i of key k; only meaningful for i below the key length
	function automatic logic [7:0] key_byte(int k, logic [3:0] i);
		logic [3:0] idx;
		idx = 4'(KEY_LEN[k] - 5'd1 - {1'b0, i});
		return KEY_STR[k][{idx, 3'b000} +: 8];
	endfunction

	function automatic parse_state_t key_char(parse_state_t s, logic [7:0] b);
		parse_state_t r;
		r = s;
		for (int k = 0; k < NUM_KEYS; k++) begin
			if (s.cand[k] && (s.key_len >= KEY_LEN[k] || key_byte(k, s.key_len[3:0]) != b))
				r.cand[k] = 1'b0;
		end
		if (s.key_len != 5'd31)
			r.key_len = s.key_len + 5'd1;
		return r;
	endfunction

	function automatic parse_state_t end_token(parse_state_t s);
		parse_state_t r;
		logic found;
		r = s;
		found = 1'b0;
		if (s.phase == PH_KEY || s.phase == PH_EQ) begin
			r.failed = 1'b1;
		end else if (s.phase == PH_VAL && s.cand != '0) begin
			if (s.val_bad) begin
				r.failed = 1'b1;
			end else begin
				for (int k = 0; k < NUM_KEYS; k++) begin
					if (s.cand[k] && !found) begin
						r.vals[k] = s.acc;
						found = 1'b1;
					end
				end
			end
		end
		r.phase = PH_GAP;
		return r;
	endfunction

	function automatic parse_state_t process_byte(parse_state_t s, logic [7:0] b);
		parse_state_t r;
		logic [67:0] prod;
		logic [NUM_KEYS-1:0] exact;
		r = s;
		prod = '0;
		exact = '0;
		if (!s.failed) begin
			if (s.prefix_pos < PREFIX_LEN) begin
				if (b == prefix_byte(s.prefix_pos[2:0]))
					r.prefix_pos = s.prefix_pos + 4'd1;
				else
					r.failed = 1'b1;
			end else if (s.prefix_pos == PREFIX_LEN) begin
				if (b == CH_SPACE)
					r.prefix_pos = POS_BODY;
				else
					r.failed = 1'b1;
			end else if (b == CH_SPACE) begin
				r = end_token(s);
			end else begin
				case (s.phase)
					PH_GAP: begin
						if (b == CH_EQ) begin
							r.failed = 1'b1;
						end else begin
							r.phase   = PH_KEY;
							r.key_len = '0;
							r.cand    = '1;
							r = key_char(r, b);
						end
					end
					PH_KEY: begin
						if (b == CH_EQ) begin
							for (int k = 0; k < NUM_KEYS; k++)
								exact[k] = s.cand[k] && (s.key_len == KEY_LEN[k]);
							r.cand    = exact;
							r.phase   = PH_EQ;
							r.acc     = '0;
							r.val_bad = 1'b0;
						end else begin
							r = key_char(s, b);
						end
					end
					default: begin
						r.phase = PH_VAL;
						if (s.cand != '0 && !s.val_bad) begin
							if (b >= CH_ZERO && b <= CH_NINE) begin
								// acc*10 + digit, exact in 68 bits
								prod = 68'({s.acc, 3'b000}) + 68'({s.acc, 1'b0})
									+ 68'(b - CH_ZERO);
								if (prod[67:64] != 4'd0)
									r.val_bad = 1'b1;
								else
									r.acc = prod[63:0];
							end else begin
								r.val_bad = 1'b1;
							end
						end
					end
				endcase
			end
		end
		return r;
	endfunction

	function automatic parse_state_t finish_line(parse_state_t s);
		parse_state_t r;
		r = s;
		if (!s.failed) begin
			if (s.prefix_pos < PREFIX_LEN)
				r.failed = 1'b1;
			else
				r = end_token(s);
		end
		return r;
	endfunction

endpackage

### src/mlp_in_if.sv
interface mlp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

### src/mlp_out_if.sv
interface mlp_out_if;
	logic        valid;
	logic        ready;
	logic        line_ok;
	logic [63:0] uptime_seconds;
	logic [63:0] active_count;
	logic [63:0] accepted_count;
	logic [63:0] disconnected_count;
	logic [63:0] device_count;
	logic [63:0] received_count;
	logic [63:0] acks_sent_count;
	logic [63:0] parse_error_count;
	logic [63:0] broadcast_error_count;
	logic [63:0] messages_per_second;

	modport source (
		output valid, output line_ok, output uptime_seconds, output active_count,
		output accepted_count, output disconnected_count, output device_count,
		output received_count, output acks_sent_count, output parse_error_count,
		output broadcast_error_count, output messages_per_second, input ready
	);
	modport sink (
		input valid, input line_ok, input uptime_seconds, input active_count,
		input accepted_count, input disconnected_count, input device_count,
		input received_count, input acks_sent_count, input parse_error_count,
		input broadcast_error_count, input messages_per_second, output ready
	);
endinterface

### src/mlp_front.sv
`include "assert_macros.svh"

module mlp_front (
	input  logic               clk,
	input  logic               arst_n,
	mlp_in_if.sink             line_ch,
	input  logic               advance,
	output logic               cap_valid,
	output mlp_pkg::tail_item_t cap_item
);

	logic [7:0]            held_q [2];
	logic [1:0]            held_cnt_q;
	mlp_pkg::parse_state_t st_q;
	logic                  accept;
	logic [2:0][7:0]       tb;
	logic [1:0]            n;

	assign line_ch.ready = advance;
	assign accept = line_ch.valid && line_ch.ready;

	// Gather the line tail and strip one LF, then one CR
	always_comb begin
		tb = '0;
		n  = 2'd1;
		case (held_cnt_q)
			2'd0: begin
				tb[0] = line_ch.data_byte;
				n = 2'd1;
			end
			2'd1: begin
				tb[0] = held_q[0];
				tb[1] = line_ch.data_byte;
				n = 2'd2;
			end
			default: begin
				tb[0] = held_q[0];
				tb[1] = held_q[1];
				tb[2] = line_ch.data_byte;
				n = 2'd3;
			end
		endcase
		if (tb[n - 2'd1] == mlp_pkg::CH_LF)
			n = n - 2'd1;
		if (n != 2'd0 && tb[n - 2'd1] == mlp_pkg::CH_CR)
			n = n - 2'd1;
	end

	assign cap_valid      = accept && line_ch.last_byte;
	assign cap_item.st    = st_q;
	assign cap_item.bytes = tb;
	assign cap_item.count = n;

	// Held-byte count and running parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cnt_q <= 2'd0;
			st_q       <= mlp_pkg::init_state();
		end else if (accept) begin
			if (line_ch.last_byte) begin
				held_cnt_q <= 2'd0;
				st_q       <= mlp_pkg::init_state();
			end else if (held_cnt_q == 2'd2) begin
				st_q <= mlp_pkg::process_byte(st_q, held_q[0]);
			end else begin
				held_cnt_q <= held_cnt_q + 2'd1;
			end
		end
	end

	// Two-byte hold line
	always_ff @(posedge clk) begin
		if (accept && !line_ch.last_byte) begin
			if (held_cnt_q == 2'd2) begin
				held_q[0] <= held_q[1];
				held_q[1] <= line_ch.data_byte;
			end else begin
				held_q[held_cnt_q[0]] <= line_ch.data_byte;
			end
		end
	end

	`ASSERT_ALWAYS(a_held_cnt_max, held_cnt_q != 2'd3, "held count above two")
	`ASSERT_NEXT(a_held_clear, accept && line_ch.last_byte, held_cnt_q == 2'd0,
		"held bytes not cleared after line end")

endmodule

### src/mlp_tail.sv
`include "assert_macros.svh"

module mlp_tail (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cap_valid,
	input  mlp_pkg::tail_item_t cap_item,
	output logic                advance,
	mlp_out_if.source           result_ch
);

	logic                      v_s1, v_s2, v_s3;
	mlp_pkg::tail_item_t       it_s1, it_s2, it_s3;
	mlp_pkg::tail_item_t       stage2_in, stage3_in;
	mlp_pkg::parse_state_t     last_st;
	mlp_pkg::parse_state_t     fin_st;
	logic                      out_valid_q;
	logic                      ok_q;
	logic [mlp_pkg::NUM_KEYS-1:0][63:0] vals_q;

	assign advance = !out_valid_q || result_ch.ready;

	// First and second tail bytes
	always_comb begin
		stage2_in = it_s1;
		if (it_s1.count > 2'd0)
			stage2_in.st = mlp_pkg::process_byte(it_s1.st, it_s1.bytes[0]);
		stage3_in = it_s2;
		if (it_s2.count > 2'd1)
			stage3_in.st = mlp_pkg::process_byte(it_s2.st, it_s2.bytes[1]);
	end

	// Third tail byte and line close
	always_comb begin
		last_st = it_s3.st;
		if (it_s3.count > 2'd2)
			last_st = mlp_pkg::process_byte(it_s3.st, it_s3.bytes[2]);
		fin_st = mlp_pkg::finish_line(last_st);
	end

	// Stage valids and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			v_s1        <= cap_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= v_s3;
		end
	end

	// Tail stages: one held byte each
	always_ff @(posedge clk) begin
		if (advance) begin
			it_s1  <= cap_item;
			it_s2  <= stage2_in;
			it_s3  <= stage3_in;
			ok_q   <= !fin_st.failed;
			vals_q <= fin_st.failed ? '0 : fin_st.vals;
		end
	end

	assign result_ch.valid                 = out_valid_q;
	assign result_ch.line_ok               = ok_q;
	assign result_ch.uptime_seconds        = vals_q[0];
	assign result_ch.active_count          = vals_q[1];
	assign result_ch.accepted_count        = vals_q[2];
	assign result_ch.disconnected_count    = vals_q[3];
	assign result_ch.device_count          = vals_q[4];
	assign result_ch.received_count        = vals_q[5];
	assign result_ch.acks_sent_count       = vals_q[6];
	assign result_ch.parse_error_count     = vals_q[7];
	assign result_ch.broadcast_error_count = vals_q[8];
	assign result_ch.messages_per_second   = vals_q[9];

	`ASSERT_IMPLIES(a_reject_zero, out_valid_q && !ok_q, vals_q == '0,
		"rejected line carries nonzero values")
	`ASSERT_NEXT(a_result_held, out_valid_q && !result_ch.ready, out_valid_q,
		"result dropped while stalled")

endmodule

### src/metrics_line_parser.sv
// METRICS line parser. Takes one byte of a text line per cycle on line_ch, with
// last_byte marking the line end, and returns one result per line on result_ch:
// line_ok and the ten key values (zero when absent, all zero on reject). Bytes
// are accepted every cycle, back to back across lines; the input stalls only
// while a finished result is held because result_ch is not ready. The last two
// bytes are held back until the line end is known, and the up to three tail
// bytes left after LF/CR stripping are parsed in three tail stages before the
// result register.
module metrics_line_parser (
	input  logic      clk,
	input  logic      arst_n,
	mlp_in_if.sink    line_ch,
	mlp_out_if.source result_ch
);

	logic                advance;
	logic                cap_valid;
	mlp_pkg::tail_item_t cap_item;

	mlp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.line_ch   (line_ch),
		.advance   (advance),
		.cap_valid (cap_valid),
		.cap_item  (cap_item)
	);

	mlp_tail u_tail (
		.clk       (clk),
		.arst_n    (arst_n),
		.cap_valid (cap_valid),
		.cap_item  (cap_item),
		.advance   (advance),
		.result_ch (result_ch)
	);

endmodule
